[rtl/alert_event_hysteresis_fsm_assert.svh]
// assertion macros shared by the alert hysteresis rtl
`ifndef ALERT_EVENT_HYSTERESIS_FSM_ASSERT_SVH
`define ALERT_EVENT_HYSTERESIS_FSM_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define AEHF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aehf assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define AEHF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aehf assertion failed");

`endif

[rtl/aehf_pkg.sv]
// shared widths, codes and reset values of the alert hysteresis block
`default_nettype none

package aehf_pkg;

  // payload widths
  localparam int unsigned EventW    = 2;
  localparam int unsigned StateW    = 2;
  localparam int unsigned WideW     = 32;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned CfgIndexW = 3;

  // default evidence counter width
  localparam int unsigned CountBitsDefault = 16;

  // event codes
  localparam logic [EventW-1:0] EvNone    = 2'd0;
  localparam logic [EventW-1:0] EvSingle  = 2'd1;
  localparam logic [EventW-1:0] EvMulti   = 2'd2;
  localparam logic [EventW-1:0] EvConfirm = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegEnterSuspect = 3'd0;
  localparam logic [CfgIndexW-1:0] RegEnterAlarm   = 3'd1;
  localparam logic [CfgIndexW-1:0] RegLeaveSuspect = 3'd2;
  localparam logic [CfgIndexW-1:0] RegLeaveAlarm   = 3'd3;
  localparam logic [CfgIndexW-1:0] RegCooldownLen  = 3'd4;

  // register reset values
  localparam logic [LimitW-1:0] EnterSuspectRst = 16'd3;
  localparam logic [LimitW-1:0] EnterAlarmRst   = 16'd3;
  localparam logic [LimitW-1:0] LeaveSuspectRst = 16'd10;
  localparam logic [LimitW-1:0] LeaveAlarmRst   = 16'd15;
  localparam logic [LimitW-1:0] CooldownLenRst  = 16'd30;

endpackage

`default_nettype wire

[rtl/aehf_in_if.sv]
// input channel carrying one frame event code per transaction
`default_nettype none

interface aehf_in_if
  import aehf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

[rtl/aehf_out_if.sv]
// result channel carrying the alert status of one frame per transaction
`default_nettype none

interface aehf_out_if
  import aehf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [StateW-1:0] alert_state;
  logic              alarm_active;
  logic              state_changed;
  logic [WideW-1:0]  frames_in_state;
  logic [WideW-1:0]  alarm_frames_total;

  modport source (
    output valid, output alert_state, output alarm_active, output state_changed,
    output frames_in_state, output alarm_frames_total, input ready
  );
  modport sink (
    input valid, input alert_state, input alarm_active, input state_changed,
    input frames_in_state, input alarm_frames_total, output ready
  );
endinterface

`default_nettype wire

[rtl/aehf_cfg_if.sv]
// configuration write channel: register index and write data
`default_nettype none

interface aehf_cfg_if
  import aehf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [LimitW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/alert_event_hysteresis_fsm.sv]
// an accepted event waits in the input stage, then its result is captured in
// the result register; throughput: one event per cycle while the sink takes
// data, set by the single input stage feeding the combinational state update
// the result register frees the input stage when it is empty or the sink takes data
// reset: asynchronous, mode idle, all counters zero, limits at default values
`default_nettype none

`include "alert_event_hysteresis_fsm_assert.svh"

module alert_event_hysteresis_fsm
  import aehf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  aehf_cfg_if.sink   cfg_i,
  aehf_in_if.sink    in_i,
  aehf_out_if.source out_o
);

  localparam int unsigned CmpW = (COUNT_BITS > LimitW) ? COUNT_BITS : LimitW;

  typedef enum logic [StateW-1:0] {
    ModeIdle    = 2'd0,
    ModeSuspect = 2'd1,
    ModeAlarm   = 2'd2,
    ModeCool    = 2'd3
  } mode_e;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // saturating add of a small step
  function automatic cnt_t sat_add(input cnt_t v, input logic [1:0] k);
    logic [COUNT_BITS:0] s;
    s = {1'b0, v} + {{(COUNT_BITS - 1){1'b0}}, k};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  // subtract a small step, floor at zero
  function automatic cnt_t floor_sub(input cnt_t v, input logic [1:0] k);
    cnt_t kx;
    kx = {{(COUNT_BITS - 2){1'b0}}, k};
    return (v > kx) ? (v - kx) : '0;
  endfunction

  // counter against a 16-bit limit
  function automatic logic reached(input cnt_t v, input logic [LimitW-1:0] lim);
    return CmpW'(v) >= CmpW'(lim);
  endfunction

  // limit registers
  logic [LimitW-1:0] enter_suspect_q, enter_alarm_q, leave_suspect_q;
  logic [LimitW-1:0] leave_alarm_q, cool_len_q;

  // input stage
  logic              s1_valid_q;
  logic [EventW-1:0] s1_event_q;

  // machine state
  mode_e            mode_q, mode_d;
  logic [WideW-1:0] dwell_q, dwell_d;
  logic [WideW-1:0] total_q, total_d;
  cnt_t             susp_q, susp_d;
  cnt_t             quiet_q, quiet_d;
  cnt_t             conf_q, conf_d;
  cnt_t             cool_q, cool_d;

  // result register
  logic              out_valid_q;
  logic [StateW-1:0] out_state_q;
  logic              out_alarm_q;
  logic              out_changed_q;
  logic [WideW-1:0]  out_dwell_q;
  logic [WideW-1:0]  out_total_q;

  logic step_en;
  logic in_take;
  logic cfg_take;

  // handshakes
  assign step_en  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || step_en;
  assign in_take  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_take = cfg_i.valid;

  // per-frame update of the alert machine
  always_comb begin
    logic [WideW-1:0] dwell_inc;
    dwell_inc = (dwell_q == '1) ? dwell_q : dwell_q + 1'b1;
    mode_d  = mode_q;
    total_d = total_q;
    susp_d  = susp_q;
    quiet_d = quiet_q;
    conf_d  = conf_q;
    cool_d  = cool_q;
    case (mode_q)
      ModeIdle: begin
        if (s1_event_q != EvNone) begin
          susp_d  = sat_add(susp_q, s1_event_q);
          quiet_d = '0;
        end else begin
          susp_d  = floor_sub(susp_q, 2'd1);
          quiet_d = sat_add(quiet_q, 2'd1);
        end
        if (reached(susp_d, enter_suspect_q)) begin
          mode_d = ModeSuspect;
          susp_d = '0;
        end
      end
      ModeSuspect: begin
        if (s1_event_q == EvConfirm || s1_event_q == EvMulti) begin
          conf_d  = sat_add(conf_q, (s1_event_q == EvConfirm) ? 2'd1 : 2'd2);
          quiet_d = '0;
          if (reached(conf_d, enter_alarm_q)) begin
            mode_d = ModeAlarm;
            conf_d = '0;
          end
        end else if (s1_event_q == EvNone) begin
          quiet_d = sat_add(quiet_q, 2'd1);
          conf_d  = floor_sub(conf_q, 2'd1);
          if (reached(quiet_d, leave_suspect_q)) begin
            mode_d  = ModeIdle;
            quiet_d = '0;
          end
        end else begin
          quiet_d = floor_sub(quiet_q, 2'd1);
        end
      end
      ModeAlarm: begin
        total_d = (total_q == '1) ? total_q : total_q + 1'b1;
        if (s1_event_q == EvNone || s1_event_q == EvSingle) begin
          quiet_d = sat_add(quiet_q, 2'd1);
          if (reached(quiet_d, leave_alarm_q)) begin
            mode_d  = ModeCool;
            quiet_d = '0;
            cool_d  = '0;
          end
        end else begin
          quiet_d = floor_sub(quiet_q, 2'd2);
        end
      end
      ModeCool: begin
        cool_d = sat_add(cool_q, 2'd1);
        if (s1_event_q == EvConfirm) begin
          mode_d  = ModeAlarm;
          cool_d  = '0;
          quiet_d = '0;
        end else if (reached(cool_d, cool_len_q)) begin
          mode_d  = ModeIdle;
          cool_d  = '0;
          total_d = '0;
        end
      end
      default: begin
        mode_d = ModeIdle;
      end
    endcase
    dwell_d = (mode_d != mode_q) ? '0 : dwell_inc;
  end

  // all registers: limits, input stage, machine state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_suspect_q <= EnterSuspectRst;
      enter_alarm_q   <= EnterAlarmRst;
      leave_suspect_q <= LeaveSuspectRst;
      leave_alarm_q   <= LeaveAlarmRst;
      cool_len_q      <= CooldownLenRst;
      s1_valid_q      <= 1'b0;
      s1_event_q      <= EvNone;
      mode_q          <= ModeIdle;
      dwell_q         <= '0;
      total_q         <= '0;
      susp_q          <= '0;
      quiet_q         <= '0;
      conf_q          <= '0;
      cool_q          <= '0;
      out_valid_q     <= 1'b0;
      out_state_q     <= ModeIdle;
      out_alarm_q     <= 1'b0;
      out_changed_q   <= 1'b0;
      out_dwell_q     <= '0;
      out_total_q     <= '0;
    end else begin
      // configuration writes, unknown indexes ignored
      if (cfg_take) begin
        case (cfg_i.index)
          RegEnterSuspect: enter_suspect_q <= cfg_i.data;
          RegEnterAlarm:   enter_alarm_q   <= cfg_i.data;
          RegLeaveSuspect: leave_suspect_q <= cfg_i.data;
          RegLeaveAlarm:   leave_alarm_q   <= cfg_i.data;
          RegCooldownLen:  cool_len_q      <= cfg_i.data;
          default: begin
          end
        endcase
      end
      // input stage
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (in_take) begin
        s1_event_q <= in_i.event_code;
      end
      // state update and result capture
      if (step_en) begin
        mode_q        <= mode_d;
        dwell_q       <= dwell_d;
        total_q       <= total_d;
        susp_q        <= susp_d;
        quiet_q       <= quiet_d;
        conf_q        <= conf_d;
        cool_q        <= cool_d;
        out_state_q   <= mode_d;
        out_alarm_q   <= (mode_d == ModeAlarm);
        out_changed_q <= (mode_d != mode_q);
        out_dwell_q   <= dwell_d;
        out_total_q   <= total_d;
      end
      out_valid_q <= step_en || (out_valid_q && !out_o.ready);
    end
  end

  // result outputs
  assign out_o.valid              = out_valid_q;
  assign out_o.alert_state        = out_state_q;
  assign out_o.alarm_active       = out_alarm_q;
  assign out_o.state_changed      = out_changed_q;
  assign out_o.frames_in_state    = out_dwell_q;
  assign out_o.alarm_frames_total = out_total_q;

  // checks
  `AEHF_ASSERT_NOW(a_change_clears_dwell, out_valid_q && out_changed_q, out_dwell_q == '0)
  `AEHF_ASSERT_NOW(a_no_alarm_total_when_quiet,
                   mode_q == ModeIdle || mode_q == ModeSuspect, total_q == '0)
  `AEHF_ASSERT_NOW(a_cool_count_only_in_cooldown, mode_q != ModeCool, cool_q == '0)
  `AEHF_ASSERT_NEXT(a_input_stage_holds, s1_valid_q && !step_en,
                    s1_valid_q && $stable(s1_event_q))

endmodule

`default_nettype wire
